/* rtl/sqr_pkg.sv */
// shared types, constants and tables for the sprite quad rotator
package sqr_pkg;

    // field widths
    localparam int POS_BITS   = 20;
    localparam int ANGLE_BITS = 16;
    localparam int WIDTH_W    = 10;
    localparam int OFFSET_W   = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;

    // center coordinate, wide enough for position plus half size plus offset
    localparam int CTR_W = ((POS_BITS > 16) ? POS_BITS : 16) + 2;

    // signed pixel offset of a corner from the center
    localparam int PIX_W = WIDTH_W + 1;

    // sine and cosine in Q1.14
    localparam int TRIG_W   = 16;
    localparam int TRIG_ONE = 16384;

    // products of pixel offsets and Q1.14 trig values
    localparam int PROD_W    = PIX_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ROT_SHIFT = 14 - 4;
    localparam int ROT_W     = 16;

    // cordic datapath
    localparam int CORDIC_ITERS    = 16;
    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
    localparam int XY_W            = 34;
    localparam int Z_W             = 32;
    localparam int PHASE_W         = 30;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] CORDIC_RND = XY_W'(32768);
    localparam int CORDIC_OUT_SHIFT = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAD_WIDTH  = 2'd0,
        REG_QUAD_HEIGHT = 2'd1,
        REG_OFFSET_X    = 2'd2,
        REG_OFFSET_Y    = 2'd3
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic signed [POS_BITS-1:0]   pos_x;
        logic signed [POS_BITS-1:0]   pos_y;
        logic        [ANGLE_BITS-1:0] angle;
    } in_item_t;

    // result item
    typedef struct packed {
        logic signed [POS_BITS-1:0] corner0_x;
        logic signed [POS_BITS-1:0] corner0_y;
        logic signed [POS_BITS-1:0] corner1_x;
        logic signed [POS_BITS-1:0] corner1_y;
        logic signed [POS_BITS-1:0] corner2_x;
        logic signed [POS_BITS-1:0] corner2_y;
        logic signed [POS_BITS-1:0] corner3_x;
        logic signed [POS_BITS-1:0] corner3_y;
    } out_item_t;

    // arctangent table, 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = 32'sh20000000;
            1:       val = 32'sh12E4051E;
            2:       val = 32'sh09FB385B;
            3:       val = 32'sh051111D4;
            4:       val = 32'sh028B0D43;
            5:       val = 32'sh0145D7E1;
            6:       val = 32'sh00A2F61E;
            7:       val = 32'sh00517C55;
            8:       val = 32'sh0028BE53;
            9:       val = 32'sh00145F2F;
            10:      val = 32'sh000A2F98;
            11:      val = 32'sh000517CC;
            12:      val = 32'sh00028BE6;
            13:      val = 32'sh000145F3;
            14:      val = 32'sh0000A2FA;
            15:      val = 32'sh0000517D;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/sqr_cordic.sv */
// pipelined rotation-mode cordic giving Q1.14 cosine and sine of a binary angle
module sqr_cordic
    import sqr_pkg::*;
#(
    parameter int TAG_W = 2 * CTR_W
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ANGLE_BITS-1:0]    in_angle,
    input  logic [TAG_W-1:0]         in_tag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TRIG_W-1:0] out_cos,
    output logic signed [TRIG_W-1:0] out_sin,
    output logic [TAG_W-1:0]         out_tag
);

    // iteration stage registers
    logic [CORDIC_STAGES-1:0] it_valid_reg;
    logic signed [XY_W-1:0]   x_reg    [CORDIC_STAGES];
    logic signed [XY_W-1:0]   y_reg    [CORDIC_STAGES];
    logic signed [Z_W-1:0]    z_reg    [CORDIC_STAGES];
    logic [1:0]               quad_reg [CORDIC_STAGES];
    logic [TAG_W-1:0]         tag_reg  [CORDIC_STAGES];

    logic signed [XY_W-1:0]   x_next   [CORDIC_STAGES];
    logic signed [XY_W-1:0]   y_next   [CORDIC_STAGES];
    logic signed [Z_W-1:0]    z_next   [CORDIC_STAGES];

    // final rounding stage
    logic                     fin_valid_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [TAG_W-1:0]         fin_tag_reg;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;

    // stage load enables, a stage loads when empty or when it drains
    logic [CORDIC_STAGES:0] adv;

    // starting angle inside the quadrant
    logic signed [Z_W-1:0] z_start;
    logic [1:0]            quad_start;

    assign z_start    = {2'b00, in_angle[ANGLE_BITS-3:0], {(PHASE_W-ANGLE_BITS+2){1'b0}}};
    assign quad_start = in_angle[ANGLE_BITS-1:ANGLE_BITS-2];

    // stall chain from the output back to the input
    always_comb
    begin
        adv[CORDIC_STAGES] = !fin_valid_reg || !out_stall;
        for (int s = CORDIC_STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !it_valid_reg[s] || adv[s+1];
        end
    end

    assign in_stall = !adv[0];

    // iteration stages, two micro-rotations each
    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        logic signed [XY_W-1:0] x_src;
        logic signed [XY_W-1:0] y_src;
        logic signed [Z_W-1:0]  z_src;
        logic                   v_src;
        logic [1:0]             quad_src;
        logic [TAG_W-1:0]       tag_src;

        if (s == 0)
        begin : g_first
            assign x_src    = CORDIC_X0;
            assign y_src    = '0;
            assign z_src    = z_start;
            assign v_src    = in_valid;
            assign quad_src = quad_start;
            assign tag_src  = in_tag;
        end
        else
        begin : g_rest
            assign x_src    = x_reg[s-1];
            assign y_src    = y_reg[s-1];
            assign z_src    = z_reg[s-1];
            assign v_src    = it_valid_reg[s-1];
            assign quad_src = quad_reg[s-1];
            assign tag_src  = tag_reg[s-1];
        end

        // micro-rotations of this stage
        always_comb
        begin
            logic signed [XY_W-1:0] xa;
            logic signed [XY_W-1:0] ya;
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            logic signed [Z_W-1:0]  za;
            xa = x_src;
            ya = y_src;
            za = z_src;
            for (int k = 0; k < ITERS_PER_STAGE; k++)
            begin
                xs = xa >>> (s * ITERS_PER_STAGE + k);
                ys = ya >>> (s * ITERS_PER_STAGE + k);
                if (!za[Z_W-1])
                begin
                    xa = xa - ys;
                    ya = ya + xs;
                    za = za - atan_entry(s * ITERS_PER_STAGE + k);
                end
                else
                begin
                    xa = xa + ys;
                    ya = ya - xs;
                    za = za + atan_entry(s * ITERS_PER_STAGE + k);
                end
            end
            x_next[s] = xa;
            y_next[s] = ya;
            z_next[s] = za;
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_valid_reg[s] <= 1'b0;
            end
            else if (adv[s])
            begin
                it_valid_reg[s] <= v_src;
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                x_reg[s]    <= x_next[s];
                y_reg[s]    <= y_next[s];
                z_reg[s]    <= z_next[s];
                quad_reg[s] <= quad_src;
                tag_reg[s]  <= tag_src;
            end
        end
    end

    // round to Q1.14, clamp to plus or minus one, fold the quadrant back in
    always_comb
    begin
        logic signed [XY_W-1:0]   xr;
        logic signed [XY_W-1:0]   yr;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] sn;
        xr = (x_reg[CORDIC_STAGES-1] + CORDIC_RND) >>> CORDIC_OUT_SHIFT;
        yr = (y_reg[CORDIC_STAGES-1] + CORDIC_RND) >>> CORDIC_OUT_SHIFT;
        if (xr > XY_W'(TRIG_ONE))
            c = TRIG_W'(TRIG_ONE);
        else if (xr < -XY_W'(TRIG_ONE))
            c = -TRIG_W'(TRIG_ONE);
        else
            c = xr[TRIG_W-1:0];
        if (yr > XY_W'(TRIG_ONE))
            sn = TRIG_W'(TRIG_ONE);
        else if (yr < -XY_W'(TRIG_ONE))
            sn = -TRIG_W'(TRIG_ONE);
        else
            sn = yr[TRIG_W-1:0];
        case (quad_reg[CORDIC_STAGES-1])
            2'd0:
            begin
                cos_next = c;
                sin_next = sn;
            end
            2'd1:
            begin
                cos_next = -sn;
                sin_next = c;
            end
            2'd2:
            begin
                cos_next = -c;
                sin_next = -sn;
            end
            default:
            begin
                cos_next = sn;
                sin_next = -c;
            end
        endcase
    end

    // output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (adv[CORDIC_STAGES])
        begin
            fin_valid_reg <= it_valid_reg[CORDIC_STAGES-1];
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (adv[CORDIC_STAGES])
        begin
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            fin_tag_reg <= tag_reg[CORDIC_STAGES-1];
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_tag   = fin_tag_reg;

endmodule

/* rtl/sprite_quad_rotator_top.sv */
// sprite quad rotator: rotates the four corners of a sprite quad about its center
//
//   channel | direction | handshake           | payload
//   cfg     | in        | cfg_write           | cfg_index, cfg_data
//   in      | in        | in_valid / in_stall | in_data (pos_x, pos_y, angle)
//   out     | out       | out_valid/out_stall | out_data (four corners, x and y)
//
// one item per cycle while the output does not stall; twelve register stages:
// 9 cordic stages (eight of two micro-rotations each, then rounding),
// then product, rotate-and-round and add-and-saturate stages.
// reset clears all valid bits and loads the registers with 16, 16, 0, 0.
// a stall at the output lets bubbles close up; the input stalls only when every stage is full.
module sprite_quad_rotator_top
    import sqr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    localparam int TAG_W = 2 * CTR_W;

    // configuration registers
    logic [WIDTH_W-1:0]         quad_width_reg;
    logic [WIDTH_W-1:0]         quad_height_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg;
    logic signed [OFFSET_W-1:0] offset_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_width_reg  <= WIDTH_W'(16);
            quad_height_reg <= WIDTH_W'(16);
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_QUAD_WIDTH:  quad_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_QUAD_HEIGHT: quad_height_reg <= cfg_data[WIDTH_W-1:0];
                REG_OFFSET_X:    offset_x_reg    <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_Y:    offset_y_reg    <= cfg_data[OFFSET_W-1:0];
                default:         ;
            endcase
        end
    end

    // quad center, carried alongside the angle through the cordic
    logic signed [CTR_W-1:0] ctr_x_in;
    logic signed [CTR_W-1:0] ctr_y_in;

    always_comb
    begin
        ctr_x_in = {{(CTR_W-POS_BITS){in_data.pos_x[POS_BITS-1]}}, in_data.pos_x}
                 + CTR_W'({quad_width_reg[WIDTH_W-1:1], 4'b0000})
                 + {{(CTR_W-OFFSET_W-4){offset_x_reg[OFFSET_W-1]}}, offset_x_reg, 4'b0000};
        ctr_y_in = {{(CTR_W-POS_BITS){in_data.pos_y[POS_BITS-1]}}, in_data.pos_y}
                 + CTR_W'({quad_height_reg[WIDTH_W-1:1], 4'b0000})
                 + {{(CTR_W-OFFSET_W-4){offset_y_reg[OFFSET_W-1]}}, offset_y_reg, 4'b0000};
    end

    // corner offsets from the center in whole pixels
    logic signed [PIX_W-1:0] dx_pix [2];
    logic signed [PIX_W-1:0] dy_pix [2];

    always_comb
    begin
        dx_pix[0] = PIX_W'(0) - {2'b00, quad_width_reg[WIDTH_W-1:1]};
        dx_pix[1] = {1'b0, quad_width_reg} - {2'b00, quad_width_reg[WIDTH_W-1:1]};
        dy_pix[0] = PIX_W'(0) - {2'b00, quad_height_reg[WIDTH_W-1:1]};
        dy_pix[1] = {1'b0, quad_height_reg} - {2'b00, quad_height_reg[WIDTH_W-1:1]};
    end

    // sine and cosine
    logic                     trig_valid;
    logic                     trig_stall;
    logic signed [TRIG_W-1:0] trig_cos;
    logic signed [TRIG_W-1:0] trig_sin;
    logic [TAG_W-1:0]         trig_tag;

    sqr_cordic #(
        .TAG_W (TAG_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_angle  (in_data.angle),
        .in_tag    ({ctr_x_in, ctr_y_in}),
        .out_valid (trig_valid),
        .out_stall (trig_stall),
        .out_cos   (trig_cos),
        .out_sin   (trig_sin),
        .out_tag   (trig_tag)
    );

    // stall chain for the back stages
    logic m_valid_reg;
    logic r_valid_reg;
    logic out_valid_reg;
    logic adv_m;
    logic adv_r;
    logic adv_o;

    assign adv_o      = !out_valid_reg || !out_stall;
    assign adv_r      = !r_valid_reg || adv_o;
    assign adv_m      = !m_valid_reg || adv_r;
    assign trig_stall = !adv_m;

    // product stage
    logic signed [PROD_W-1:0] prod_xc_reg [2];
    logic signed [PROD_W-1:0] prod_xs_reg [2];
    logic signed [PROD_W-1:0] prod_yc_reg [2];
    logic signed [PROD_W-1:0] prod_ys_reg [2];
    logic [TAG_W-1:0]         m_tag_reg;
    logic signed [PROD_W-1:0] cos_ext;
    logic signed [PROD_W-1:0] sin_ext;
    logic signed [PROD_W-1:0] dx_ext [2];
    logic signed [PROD_W-1:0] dy_ext [2];

    always_comb
    begin
        cos_ext = {{PIX_W{trig_cos[TRIG_W-1]}}, trig_cos};
        sin_ext = {{PIX_W{trig_sin[TRIG_W-1]}}, trig_sin};
        for (int j = 0; j < 2; j++)
        begin
            dx_ext[j] = {{TRIG_W{dx_pix[j][PIX_W-1]}}, dx_pix[j]};
            dy_ext[j] = {{TRIG_W{dy_pix[j][PIX_W-1]}}, dy_pix[j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv_m)
        begin
            m_valid_reg <= trig_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_m)
        begin
            for (int j = 0; j < 2; j++)
            begin
                prod_xc_reg[j] <= dx_ext[j] * cos_ext;
                prod_xs_reg[j] <= dx_ext[j] * sin_ext;
                prod_yc_reg[j] <= dy_ext[j] * cos_ext;
                prod_ys_reg[j] <= dy_ext[j] * sin_ext;
            end
            m_tag_reg <= trig_tag;
        end
    end

    // rotate and round to 4 fraction bits
    logic signed [ROT_W-1:0] rot_x_reg  [4];
    logic signed [ROT_W-1:0] rot_y_reg  [4];
    logic signed [ROT_W-1:0] rot_x_next [4];
    logic signed [ROT_W-1:0] rot_y_next [4];
    logic [TAG_W-1:0]        r_tag_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        for (int k = 0; k < 4; k++)
        begin
            sx = {prod_xc_reg[k%2][PROD_W-1], prod_xc_reg[k%2]}
               - {prod_ys_reg[k/2][PROD_W-1], prod_ys_reg[k/2]}
               + SUM_W'(1 << (ROT_SHIFT - 1));
            sy = {prod_xs_reg[k%2][PROD_W-1], prod_xs_reg[k%2]}
               + {prod_yc_reg[k/2][PROD_W-1], prod_yc_reg[k/2]}
               + SUM_W'(1 << (ROT_SHIFT - 1));
            rot_x_next[k] = sx[ROT_W+ROT_SHIFT-1:ROT_SHIFT];
            rot_y_next[k] = sy[ROT_W+ROT_SHIFT-1:ROT_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv_r)
        begin
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_r)
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            r_tag_reg <= m_tag_reg;
        end
    end

    // add the center and saturate to the position range
    function automatic logic signed [POS_BITS-1:0] add_sat(
        input logic signed [CTR_W-1:0] ctr,
        input logic signed [ROT_W-1:0] rot
    );
        logic signed [CTR_W:0]      s;
        logic signed [POS_BITS-1:0] r;
        s = {ctr[CTR_W-1], ctr} + {{(CTR_W+1-ROT_W){rot[ROT_W-1]}}, rot};
        if (s[CTR_W:POS_BITS-1] == '0 || s[CTR_W:POS_BITS-1] == '1)
            r = s[POS_BITS-1:0];
        else if (s[CTR_W])
            r = {1'b1, {(POS_BITS-1){1'b0}}};
        else
            r = {1'b0, {(POS_BITS-1){1'b1}}};
        return r;
    endfunction

    out_item_t               out_reg;
    out_item_t               out_next;
    logic signed [CTR_W-1:0] r_ctr_x;
    logic signed [CTR_W-1:0] r_ctr_y;

    assign r_ctr_x = r_tag_reg[TAG_W-1:CTR_W];
    assign r_ctr_y = r_tag_reg[CTR_W-1:0];

    always_comb
    begin
        out_next.corner0_x = add_sat(r_ctr_x, rot_x_reg[0]);
        out_next.corner0_y = add_sat(r_ctr_y, rot_y_reg[0]);
        out_next.corner1_x = add_sat(r_ctr_x, rot_x_reg[1]);
        out_next.corner1_y = add_sat(r_ctr_y, rot_y_reg[1]);
        out_next.corner2_x = add_sat(r_ctr_x, rot_x_reg[2]);
        out_next.corner2_y = add_sat(r_ctr_y, rot_y_reg[2]);
        out_next.corner3_x = add_sat(r_ctr_x, rot_x_reg[3]);
        out_next.corner3_y = add_sat(r_ctr_y, rot_y_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_o)
        begin
            out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // input stalls only when the whole pipeline is full and the output is blocked
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && r_valid_reg && m_valid_reg && trig_valid))
        else $error("input stalled while the pipeline has room");

    // cordic results stay within plus or minus one
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        trig_valid |-> (trig_cos <= TRIG_W'(TRIG_ONE) && trig_cos >= -TRIG_W'(TRIG_ONE)
                        && trig_sin <= TRIG_W'(TRIG_ONE) && trig_sin >= -TRIG_W'(TRIG_ONE)))
        else $error("cordic result out of range");

    // an open output register takes exactly what the rotate stage held
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |=> (out_valid == $past(r_valid_reg)))
        else $error("result lost or invented at the output register");

endmodule
